>>> design/vts_pkg.sv
// ----------------------------------------------------------------------------
// vts_pkg: shared types and constants of the version tag scanner
// Character codes, state encodings, the date state bundle and the result
// record passed between the scanner modules.
// ----------------------------------------------------------------------------
package vts_pkg;

  // longest tag line, counted from the '$'
  localparam int unsigned LINE_LIMIT = 256;
  localparam int unsigned LINE_W     = $clog2(LINE_LIMIT);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] SAT7_MAX  = 7'd127;

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_LINE,
    SCAN_DONE
  } scan_e;

  typedef enum logic [2:0] {
    TOK_GAP,
    TOK_MAJOR,
    TOK_DOT,
    TOK_MINOR,
    TOK_SKIP
  } tok_e;

  typedef enum logic [3:0] {
    DT_NONE,
    DT_WAIT_DAY,
    DT_DAY,
    DT_WAIT_MON,
    DT_MON,
    DT_WAIT_YEAR,
    DT_YEAR,
    DT_DONE,
    DT_FAIL
  } date_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_TAG,
    ST_NO_VER,
    ST_BAD_DATE
  } status_e;

  // date parser state; the year is held as two decimal digits
  typedef struct packed {
    date_e      phase;
    logic [6:0] day;
    logic [6:0] month;
    logic [3:0] yr_tens;
    logic [3:0] yr_ones;
  } date_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] major;
    logic [15:0] minor;
    logic        has_date;
    logic [19:0] date_ymd;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // decimal value of a digit character, zero otherwise
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    v = c - CH_ZERO;
    return is_digit(c) ? v[3:0] : 4'd0;
  endfunction

endpackage

>>> design/vts_date.sv
// ----------------------------------------------------------------------------
// vts_date: date field parser step
// Next state of the (dd.mm.yy) parser for one byte of the tag line.
// ----------------------------------------------------------------------------
module vts_date (
  input  logic [7:0]     data_i,
  input  vts_pkg::date_t date_i,
  output vts_pkg::date_t date_o
);

  logic       digit;
  logic       blank;
  logic       sep;
  logic [3:0] dval;

  // day or month digit with saturation at 127
  function automatic logic [6:0] sat7(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] v;
    v = 11'(acc) * 11'd10 + 11'(d);
    return (v > 11'(vts_pkg::SAT7_MAX)) ? vts_pkg::SAT7_MAX : v[6:0];
  endfunction

  assign digit = vts_pkg::is_digit(data_i);
  assign blank = vts_pkg::is_blank(data_i);
  assign sep   = (data_i == vts_pkg::CH_DOT) || (data_i == vts_pkg::CH_SLASH);
  assign dval  = vts_pkg::digit_val(data_i);

  // one parser step
  always_comb begin
    date_o = date_i;
    case (date_i.phase)
      vts_pkg::DT_WAIT_DAY: begin
        if (digit) begin
          date_o.day   = 7'(dval);
          date_o.phase = vts_pkg::DT_DAY;
        end else if (!blank) begin
          date_o.phase = vts_pkg::DT_FAIL;
        end
      end
      vts_pkg::DT_DAY: begin
        if (digit) begin
          date_o.day = sat7(date_i.day, dval);
        end else if (sep && (date_i.day != 7'd0) && (date_i.day <= vts_pkg::DAY_MAX)) begin
          date_o.phase = vts_pkg::DT_WAIT_MON;
        end else begin
          date_o.phase = vts_pkg::DT_FAIL;
        end
      end
      vts_pkg::DT_WAIT_MON: begin
        if (digit) begin
          date_o.month = 7'(dval);
          date_o.phase = vts_pkg::DT_MON;
        end else if (!blank) begin
          date_o.phase = vts_pkg::DT_FAIL;
        end
      end
      vts_pkg::DT_MON: begin
        if (digit) begin
          date_o.month = sat7(date_i.month, dval);
        end else if (sep && (date_i.month != 7'd0) &&
                     (date_i.month <= vts_pkg::MONTH_MAX)) begin
          date_o.phase = vts_pkg::DT_WAIT_YEAR;
        end else begin
          date_o.phase = vts_pkg::DT_FAIL;
        end
      end
      vts_pkg::DT_WAIT_YEAR: begin
        if (digit) begin
          date_o.yr_tens = 4'd0;
          date_o.yr_ones = dval;
          date_o.phase   = vts_pkg::DT_YEAR;
        end else if (!blank) begin
          date_o.phase = vts_pkg::DT_FAIL;
        end
      end
      vts_pkg::DT_YEAR: begin
        // year keeps its last two digits
        if (digit) begin
          date_o.yr_tens = date_i.yr_ones;
          date_o.yr_ones = dval;
        end else begin
          date_o.phase = vts_pkg::DT_DONE;
        end
      end
      default: begin
        date_o = date_i;
      end
    endcase
  end

endmodule

>>> design/vts_scan.sv
// ----------------------------------------------------------------------------
// vts_scan: tag search and tag line parser
// Holds the scan state, updates it for one byte per step and forms the
// result when the tag line or the file ends.
// ----------------------------------------------------------------------------
module vts_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  output logic              res_valid_o,
  output vts_pkg::res_t     res_o
);

  localparam logic [vts_pkg::LINE_W-1:0] LEN_END = vts_pkg::LINE_W'(vts_pkg::LINE_LIMIT - 1);
  localparam logic [vts_pkg::LINE_W-1:0] LEN_TAG = vts_pkg::LINE_W'(5);
  localparam vts_pkg::date_t DATE_RST = '{phase: vts_pkg::DT_NONE, default: '0};

  vts_pkg::scan_e              scan_q, scan_d;
  logic [2:0]                  tag_q, tag_d;
  logic [vts_pkg::LINE_W-1:0]  len_q, len_d, len_inc;
  vts_pkg::tok_e               tok_q, tok_d, tok_f;
  logic                        ver_q, ver_d, ver_f;
  logic [15:0]                 major_q, major_d, major_f;
  logic [15:0]                 minor_q, minor_d, minor_f;
  vts_pkg::date_t              date_q, date_d, date_f, date_step;
  logic [2:0]                  tag_m;
  logic                        digit;
  logic                        blank;
  logic                        tsep;
  logic                        term;
  logic [3:0]                  dval;

  function automatic logic [7:0] tag_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = vts_pkg::CH_DOLLAR;
      3'd1:    c = vts_pkg::CH_V;
      3'd2:    c = vts_pkg::CH_E;
      3'd3:    c = vts_pkg::CH_R;
      default: c = vts_pkg::CH_COLON;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] acc, input logic [3:0] d);
    logic [19:0] v;
    v = 20'(acc) * 20'd10 + 20'(d);
    return (v > 20'd65535) ? 16'hffff : v[15:0];
  endfunction

  // result at the end of the tag line
  function automatic vts_pkg::res_t finish(input vts_pkg::tok_e tok, input logic ver,
                                           input logic [15:0] maj, input logic [15:0] mnr,
                                           input vts_pkg::date_t dt);
    vts_pkg::res_t r;
    logic          seen;
    logic [19:0]   yy;
    r    = '{status: vts_pkg::ST_OK, default: '0};
    seen = ver || ((dt.phase == vts_pkg::DT_NONE) && (tok == vts_pkg::TOK_MINOR));
    yy   = 20'(dt.yr_tens) * 20'd10 + 20'(dt.yr_ones);
    if (!seen) begin
      r.status = vts_pkg::ST_NO_VER;
    end else if ((dt.phase != vts_pkg::DT_NONE) && (dt.phase != vts_pkg::DT_YEAR) &&
                 (dt.phase != vts_pkg::DT_DONE)) begin
      r.status = vts_pkg::ST_BAD_DATE;
    end else begin
      r.major = maj;
      r.minor = mnr;
      if (dt.phase != vts_pkg::DT_NONE) begin
        r.has_date = 1'b1;
        r.date_ymd = yy * 20'd10000 + 20'(dt.month) * 20'd100 + 20'(dt.day);
      end
    end
    return r;
  endfunction

  assign digit   = vts_pkg::is_digit(data_i);
  assign blank   = vts_pkg::is_blank(data_i);
  assign tsep    = blank || (data_i == vts_pkg::CH_LPAREN);
  assign term    = (data_i == vts_pkg::CH_NUL) || (data_i == vts_pkg::CH_LF) ||
                   (data_i == vts_pkg::CH_CR);
  assign dval    = vts_pkg::digit_val(data_i);
  assign len_inc = len_q + 1'b1;

  vts_date u_date (
    .data_i (data_i),
    .date_i (date_q),
    .date_o (date_step)
  );

  // token and date feed for one line byte
  always_comb begin
    tok_f   = tok_q;
    ver_f   = ver_q;
    major_f = major_q;
    minor_f = minor_q;
    date_f  = date_q;
    if (date_q.phase != vts_pkg::DT_NONE) begin
      date_f = date_step;
    end else begin
      case (tok_q)
        vts_pkg::TOK_GAP: begin
          if (blank) begin
            tok_f = vts_pkg::TOK_GAP;
          end else if (data_i == vts_pkg::CH_LPAREN) begin
            date_f.phase = vts_pkg::DT_WAIT_DAY;
          end else if (!ver_q && digit) begin
            major_f = 16'(dval);
            minor_f = 16'd0;
            tok_f   = vts_pkg::TOK_MAJOR;
          end else begin
            tok_f = vts_pkg::TOK_SKIP;
          end
        end
        vts_pkg::TOK_MAJOR: begin
          if (digit)                         major_f = sat16(major_q, dval);
          else if (data_i == vts_pkg::CH_DOT) tok_f  = vts_pkg::TOK_DOT;
          else                               tok_f   = tsep ? vts_pkg::TOK_GAP : vts_pkg::TOK_SKIP;
        end
        vts_pkg::TOK_DOT: begin
          if (digit) begin
            minor_f = 16'(dval);
            tok_f   = vts_pkg::TOK_MINOR;
          end else begin
            tok_f = tsep ? vts_pkg::TOK_GAP : vts_pkg::TOK_SKIP;
          end
        end
        vts_pkg::TOK_MINOR: begin
          if (digit) begin
            minor_f = sat16(minor_q, dval);
          end else if (data_i == vts_pkg::CH_DOT) begin
            ver_f = 1'b1;
            tok_f = vts_pkg::TOK_SKIP;
          end else if (tsep) begin
            ver_f = 1'b1;
            tok_f = vts_pkg::TOK_GAP;
          end else begin
            tok_f = vts_pkg::TOK_SKIP;
          end
        end
        default: begin
          if (tsep) tok_f = vts_pkg::TOK_GAP;
        end
      endcase
    end
  end

  // scan control, next state and result
  always_comb begin
    scan_d      = scan_q;
    tag_d       = tag_q;
    len_d       = len_q;
    tok_d       = tok_q;
    ver_d       = ver_q;
    major_d     = major_q;
    minor_d     = minor_q;
    date_d      = date_q;
    res_valid_o = 1'b0;
    res_o       = '{status: vts_pkg::ST_NO_TAG, default: '0};
    tag_m       = 3'd0;
    case (scan_q)
      vts_pkg::SCAN_SEARCH: begin
        if (data_i == tag_char(tag_q))          tag_m = tag_q + 3'd1;
        else if (data_i == vts_pkg::CH_DOLLAR)  tag_m = 3'd1;
        else                                    tag_m = 3'd0;
        if (tag_m == 3'd5) begin
          scan_d  = vts_pkg::SCAN_LINE;
          tag_d   = 3'd0;
          len_d   = LEN_TAG;
          tok_d   = vts_pkg::TOK_GAP;
          ver_d   = 1'b0;
          major_d = 16'd0;
          minor_d = 16'd0;
          date_d  = DATE_RST;
          res_valid_o = last_i;
          res_o = finish(vts_pkg::TOK_GAP, 1'b0, 16'd0, 16'd0, DATE_RST);
        end else begin
          tag_d       = tag_m;
          res_valid_o = last_i;
        end
      end
      vts_pkg::SCAN_LINE: begin
        if (term) begin
          res_valid_o = 1'b1;
          res_o       = finish(tok_q, ver_q, major_q, minor_q, date_q);
          scan_d      = vts_pkg::SCAN_DONE;
        end else begin
          len_d   = len_inc;
          tok_d   = tok_f;
          ver_d   = ver_f;
          major_d = major_f;
          minor_d = minor_f;
          date_d  = date_f;
          res_o   = finish(tok_f, ver_f, major_f, minor_f, date_f);
          if ((len_inc >= LEN_END) || last_i) begin
            res_valid_o = 1'b1;
            scan_d      = vts_pkg::SCAN_DONE;
          end
        end
      end
      default: begin
        scan_d = scan_q;
      end
    endcase
    // the last byte re-arms the scanner
    if (last_i) begin
      scan_d  = vts_pkg::SCAN_SEARCH;
      tag_d   = 3'd0;
      len_d   = '0;
      tok_d   = vts_pkg::TOK_GAP;
      ver_d   = 1'b0;
      major_d = 16'd0;
      minor_d = 16'd0;
      date_d  = DATE_RST;
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= vts_pkg::SCAN_SEARCH;
      tag_q   <= 3'd0;
      len_q   <= '0;
      tok_q   <= vts_pkg::TOK_GAP;
      ver_q   <= 1'b0;
      major_q <= 16'd0;
      minor_q <= 16'd0;
      date_q  <= DATE_RST;
    end else if (step_i) begin
      scan_q  <= scan_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      tok_q   <= tok_d;
      ver_q   <= ver_d;
      major_q <= major_d;
      minor_q <= minor_d;
      date_q  <= date_d;
    end
  end

endmodule

>>> design/version_tag_scanner.sv
// A request accepted at the inputs reaches the outputs through the input register, then the result register.
// Throughput: one byte per cycle; each byte updates the scan state in a single pass.
// A result register decouples the output: only a byte that produces a result waits on a held result.
// Reset clears the scan state to tag search and empties both registers at once.
// ----------------------------------------------------------------------------
// version_tag_scanner: finds the first version tag of a byte stream
// Parses the tag line into major, minor and an optional date, one result
// per tag line or per file without a tag.
// ----------------------------------------------------------------------------
module version_tag_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] major_o,
  output logic [15:0] minor_o,
  output logic        has_date_o,
  output logic [19:0] date_ymd_o
);

  logic          in_valid_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          out_valid_q;
  vts_pkg::res_t res_q;
  vts_pkg::res_t res;
  logic          res_valid;
  logic          advance;
  logic          step;

  // the result register can take a result; a byte without a result always moves on
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (advance || !res_valid);
  assign in_stall_o = in_valid_q && res_valid && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  vts_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_i      (byte_q),
    .last_i      (last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign major_o     = res_q.major;
  assign minor_o     = res_q.minor;
  assign has_date_o  = res_q.has_date;
  assign date_ymd_o  = res_q.date_ymd;

endmodule
